>>> hdl/i2cbb_pkg.sv
// Shared types and constants for the bit-banged I2C master.
// Used by every module of the block; depends on nothing else.
package i2cbb_pkg;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;
    localparam logic [7:0] STRETCH_RESET     = 8'd5;
    localparam logic [7:0] MSB_MASK          = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_STRETCH     = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_STRETCH = 2'd1,
        ERR_SDA_LOW = 2'd2,
        ERR_NACK    = 2'd3
    } err_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        ST_SCL  = 5'd1,
        ST_H1   = 5'd2,
        ST_H2   = 5'd3,
        ST_H3   = 5'd4,
        SP_H1   = 5'd5,
        SP_SCL  = 5'd6,
        SP_H2   = 5'd7,
        SP_H3   = 5'd8,
        WR_SET  = 5'd9,
        WR_SCL  = 5'd10,
        WR_HI   = 5'd11,
        WR_LO   = 5'd12,
        WA_SET  = 5'd13,
        WA_SCL  = 5'd14,
        WA_HI   = 5'd15,
        WA_LO   = 5'd16,
        RD_SET  = 5'd17,
        RD_SCL  = 5'd18,
        RD_HI   = 5'd19,
        RD_LO   = 5'd20,
        RK_SET  = 5'd21,
        RK_SCL  = 5'd22,
        RK_HI   = 5'd23,
        RK_LO   = 5'd24
    } phase_t;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] stretch_limit_ticks;
    } i2cbb_cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       final_read;
        logic       scl_level;
        logic       sda_level;
    } i2cbb_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] rx_byte;
        err_t       error_code;
    } i2cbb_result_t;

endpackage

>>> hdl/i2c_bitbang_master_top.sv
// Top level of the bit-banged I2C master: request handshakes and result register.
// Depends on i2cbb_pkg, i2cbb_cfg and i2cbb_core.
//
// Each input request is one timing tick carrying the sampled SCL and SDA levels
// and, when the master is idle, an optional command. The master accepts one
// request per clock cycle unless stalled and presents the matching result in
// the next cycle; the rate is set by the single registered step of the bus
// sequencer, and a waiting result does not stop the next request from being
// taken while the downstream side is ready. There is no start-up clearing pass.
// Configuration writes are to be made only while no request is outstanding.
module i2c_bitbang_master_top
    import i2cbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] tx_byte,
    input  logic       final_read,
    input  logic       scl_level,
    input  logic       sda_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_release,
    output logic       sda_release,
    output logic       busy_res,
    output logic       done_res,
    output logic       success,
    output logic [7:0] rx_byte,
    output logic [1:0] error_code
);

    i2cbb_cfg_t    cfg;
    i2cbb_item_t   item;
    i2cbb_result_t step_result;
    i2cbb_result_t result_reg;
    logic          out_valid_reg;
    logic          accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign item.action     = action;
    assign item.tx_byte    = tx_byte;
    assign item.final_read = final_read;
    assign item.scl_level  = scl_level;
    assign item.sda_level  = sda_level;

    i2cbb_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    i2cbb_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .item    (item),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = result_reg.scl_release;
    assign sda_release = result_reg.sda_release;
    assign busy_res    = result_reg.busy_res;
    assign done_res    = result_reg.done_res;
    assign success     = result_reg.success;
    assign rx_byte     = result_reg.rx_byte;
    assign error_code  = result_reg.error_code;

endmodule

>>> hdl/i2cbb_cfg.sv
// Configuration registers for the bit-banged I2C master.
// Depends on i2cbb_pkg for the register indexes and reset values.
module i2cbb_cfg
    import i2cbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output i2cbb_cfg_t cfg
);

    logic [7:0] half_period_reg;
    logic [7:0] stretch_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HALF_PERIOD_RESET;
            stretch_limit_reg <= STRETCH_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg   <= cfg_data;
                CFG_STRETCH:     stretch_limit_reg <= cfg_data;
                default:         half_period_reg   <= half_period_reg;
            endcase
        end
    end

    assign cfg.half_period_ticks   = half_period_reg;
    assign cfg.stretch_limit_ticks = stretch_limit_reg;

endmodule

>>> hdl/i2cbb_core.sv
// Bus sequencer of the bit-banged I2C master: state registers and the
// single-tick step logic. Depends on i2cbb_pkg.
module i2cbb_core
    import i2cbb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  i2cbb_item_t   item,
    input  i2cbb_cfg_t    cfg,
    output i2cbb_result_t result
);

    phase_t     phase_reg,         phase_next;
    logic [3:0] bit_count_reg,     bit_count_next;
    logic [7:0] shifter_reg,       shifter_next;
    logic [7:0] half_timer_reg,    half_timer_next;
    logic [7:0] stretch_timer_reg, stretch_timer_next;
    logic       clock_drive_reg,   clock_drive_next;
    logic       data_drive_reg,    data_drive_next;
    logic       nack_pending_reg,  nack_pending_next;
    err_t       last_error_reg,    last_error_next;
    logic [7:0] rx_hold_reg,       rx_hold_next;
    logic       done;
    logic       ok;
    logic [3:0] bit_count_inc;
    logic [8:0] stretch_sum;

    assign bit_count_inc = bit_count_reg + 4'd1;
    assign stretch_sum   = {1'b0, stretch_timer_reg} + 9'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shifter_next       = shifter_reg;
        half_timer_next    = half_timer_reg;
        stretch_timer_next = stretch_timer_reg;
        clock_drive_next   = clock_drive_reg;
        data_drive_next    = data_drive_reg;
        nack_pending_next  = nack_pending_reg;
        last_error_next    = last_error_reg;
        rx_hold_next       = rx_hold_reg;
        done               = 1'b0;
        ok                 = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.action >= ACT_START && item.action <= ACT_READ)
            begin
                last_error_next = ERR_NONE;
                bit_count_next  = 4'd0;
                priority if (item.action == ACT_START)
                begin
                    data_drive_next    = 1'b1;
                    clock_drive_next   = 1'b1;
                    stretch_timer_next = 8'd0;
                    phase_next         = ST_SCL;
                end
                else if (item.action == ACT_STOP)
                begin
                    clock_drive_next = 1'b0;
                    data_drive_next  = 1'b0;
                    phase_next       = SP_H1;
                    half_timer_next  = cfg.half_period_ticks;
                end
                else if (item.action == ACT_WRITE)
                begin
                    data_drive_next = |(item.tx_byte & MSB_MASK);
                    shifter_next    = {item.tx_byte[6:0], 1'b0};
                    phase_next      = WR_SET;
                    half_timer_next = cfg.half_period_ticks;
                end
                else
                begin
                    data_drive_next   = 1'b1;
                    shifter_next      = 8'd0;
                    nack_pending_next = item.final_read;
                    phase_next        = RD_SET;
                    half_timer_next   = cfg.half_period_ticks;
                end
            end
        end
        else if (phase_reg == ST_SCL || phase_reg == SP_SCL || phase_reg == WR_SCL ||
                 phase_reg == WA_SCL || phase_reg == RD_SCL || phase_reg == RK_SCL)
        begin
            if (item.scl_level)
            begin
                half_timer_next = cfg.half_period_ticks;
                unique case (phase_reg)
                    ST_SCL:  phase_next = ST_H1;
                    SP_SCL:  phase_next = SP_H2;
                    WR_SCL:  phase_next = WR_HI;
                    WA_SCL:  phase_next = WA_HI;
                    RD_SCL:  phase_next = RD_HI;
                    default: phase_next = RK_HI;
                endcase
            end
            else
            begin
                stretch_timer_next = stretch_sum[7:0];
                if (stretch_sum >= {1'b0, cfg.stretch_limit_ticks})
                begin
                    if (phase_reg == SP_SCL)
                    begin
                        data_drive_next = 1'b1;
                    end
                    phase_next      = PH_IDLE;
                    done            = 1'b1;
                    last_error_next = ERR_STRETCH;
                end
            end
        end
        else if (half_timer_reg > 8'd1)
        begin
            half_timer_next = half_timer_reg - 8'd1;
        end
        else
        begin
            half_timer_next = 8'd0;
            unique case (phase_reg)
                ST_H1:
                begin
                    if (!item.sda_level)
                    begin
                        phase_next      = PH_IDLE;
                        done            = 1'b1;
                        last_error_next = ERR_SDA_LOW;
                    end
                    else
                    begin
                        data_drive_next = 1'b0;
                        phase_next      = ST_H2;
                        half_timer_next = cfg.half_period_ticks;
                    end
                end
                ST_H2:
                begin
                    clock_drive_next = 1'b0;
                    phase_next       = ST_H3;
                    half_timer_next  = cfg.half_period_ticks;
                end
                ST_H3:
                begin
                    phase_next      = PH_IDLE;
                    done            = 1'b1;
                    ok              = 1'b1;
                    last_error_next = ERR_NONE;
                end
                SP_H1:
                begin
                    clock_drive_next   = 1'b1;
                    stretch_timer_next = 8'd0;
                    phase_next         = SP_SCL;
                end
                SP_H2:
                begin
                    data_drive_next = 1'b1;
                    phase_next      = SP_H3;
                    half_timer_next = cfg.half_period_ticks;
                end
                SP_H3:
                begin
                    phase_next      = PH_IDLE;
                    done            = 1'b1;
                    ok              = item.sda_level;
                    last_error_next = item.sda_level ? ERR_NONE : ERR_SDA_LOW;
                end
                WR_SET:
                begin
                    clock_drive_next   = 1'b1;
                    stretch_timer_next = 8'd0;
                    phase_next         = WR_SCL;
                end
                WR_HI:
                begin
                    clock_drive_next = 1'b0;
                    phase_next       = WR_LO;
                    half_timer_next  = cfg.half_period_ticks;
                end
                WR_LO:
                begin
                    bit_count_next  = bit_count_inc;
                    half_timer_next = cfg.half_period_ticks;
                    if (bit_count_inc < BITS_PER_BYTE)
                    begin
                        data_drive_next = |(shifter_reg & MSB_MASK);
                        shifter_next    = {shifter_reg[6:0], 1'b0};
                        phase_next      = WR_SET;
                    end
                    else
                    begin
                        data_drive_next = 1'b1;
                        phase_next      = WA_SET;
                    end
                end
                WA_SET:
                begin
                    clock_drive_next   = 1'b1;
                    stretch_timer_next = 8'd0;
                    phase_next         = WA_SCL;
                end
                WA_HI:
                begin
                    nack_pending_next = item.sda_level;
                    clock_drive_next  = 1'b0;
                    phase_next        = WA_LO;
                    half_timer_next   = cfg.half_period_ticks;
                end
                WA_LO:
                begin
                    phase_next      = PH_IDLE;
                    done            = 1'b1;
                    ok              = !nack_pending_reg;
                    last_error_next = nack_pending_reg ? ERR_NACK : ERR_NONE;
                end
                RD_SET:
                begin
                    clock_drive_next   = 1'b1;
                    stretch_timer_next = 8'd0;
                    phase_next         = RD_SCL;
                end
                RD_HI:
                begin
                    shifter_next     = {shifter_reg[6:0], item.sda_level};
                    clock_drive_next = 1'b0;
                    phase_next       = RD_LO;
                    half_timer_next  = cfg.half_period_ticks;
                end
                RD_LO:
                begin
                    bit_count_next  = bit_count_inc;
                    half_timer_next = cfg.half_period_ticks;
                    if (bit_count_inc < BITS_PER_BYTE)
                    begin
                        phase_next = RD_SET;
                    end
                    else
                    begin
                        data_drive_next = nack_pending_reg;
                        phase_next      = RK_SET;
                    end
                end
                RK_SET:
                begin
                    clock_drive_next   = 1'b1;
                    stretch_timer_next = 8'd0;
                    phase_next         = RK_SCL;
                end
                RK_HI:
                begin
                    clock_drive_next = 1'b0;
                    data_drive_next  = 1'b1;
                    phase_next       = RK_LO;
                    half_timer_next  = cfg.half_period_ticks;
                end
                RK_LO:
                begin
                    rx_hold_next    = shifter_reg;
                    phase_next      = PH_IDLE;
                    done            = 1'b1;
                    ok              = 1'b1;
                    last_error_next = ERR_NONE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.scl_release = clock_drive_next;
        result.sda_release = data_drive_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.success     = done && ok;
        result.rx_byte     = rx_hold_next;
        result.error_code  = last_error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= 4'd0;
            shifter_reg       <= 8'd0;
            half_timer_reg    <= 8'd0;
            stretch_timer_reg <= 8'd0;
            clock_drive_reg   <= 1'b1;
            data_drive_reg    <= 1'b1;
            nack_pending_reg  <= 1'b0;
            last_error_reg    <= ERR_NONE;
            rx_hold_reg       <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            shifter_reg       <= shifter_next;
            half_timer_reg    <= half_timer_next;
            stretch_timer_reg <= stretch_timer_next;
            clock_drive_reg   <= clock_drive_next;
            data_drive_reg    <= data_drive_next;
            nack_pending_reg  <= nack_pending_next;
            last_error_reg    <= last_error_next;
            rx_hold_reg       <= rx_hold_next;
        end
    end

endmodule

>>> hdl/i2cbb_checker.sv
// Port-level checks for the bit-banged I2C master, bound to the top level.
// Depends on i2cbb_pkg for the error codes.
module i2cbb_checker
    import i2cbb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       busy_res,
    input logic       done_res,
    input logic       success,
    input logic [1:0] error_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("busy after a finished command");

    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> done_res && error_code == ERR_NONE)
        else $error("success without a clean finish");

    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && !success |-> error_code != ERR_NONE)
        else $error("failed command without an error code");

endmodule

bind i2c_bitbang_master_top i2cbb_checker u_i2cbb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .success    (success),
    .error_code (error_code)
);

>>> verif/tb.sv
// Testbench for the bit-banged I2C master top level: directed commands, then random bus traffic.
// Keeps its own model of the sequencer and checks every result request in order.
// Depends on i2cbb_pkg and i2c_bitbang_master_top.
module tb;
    import i2cbb_pkg::*;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       final_read;
    logic       scl_level;
    logic       sda_level;
    logic       out_valid;
    logic       out_ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] rx_byte;
    logic [1:0] error_code;

    i2c_bitbang_master_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .tx_byte      (tx_byte),
        .final_read   (final_read),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_release  (scl_release),
        .sda_release  (sda_release),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .success      (success),
        .rx_byte      (rx_byte),
        .error_code   (error_code)
    );

    // Model of the sequencer.
    logic [7:0] half_cfg    = HALF_PERIOD_RESET;
    logic [7:0] stretch_cfg = STRETCH_RESET;
    logic [4:0] ph          = PH_IDLE;
    logic [3:0] bit_cnt     = '0;
    logic [7:0] shifter     = '0;
    logic [7:0] half_tmr    = '0;
    logic [8:0] stretch_tmr = '0;
    logic       clk_drv     = 1'b1;
    logic       dat_drv     = 1'b1;
    logic       nack_pend   = 1'b0;
    logic [1:0] err_held    = ERR_NONE;
    logic [7:0] rx_held     = '0;
    logic       step_done;
    logic       step_ok;

    i2cbb_result_t awaited_results[$];

    // Bus and traffic control.
    logic       bus_noise = 1'b0;
    logic       hold_scl  = 1'b0;
    logic       hold_sda  = 1'b0;
    logic       ack_level = 1'b0;
    logic [7:0] rd_data   = '0;
    int         stretch_left = 0;
    int         send_idle_pct = 9;
    int         recv_idle_pct = 74;
    logic       stall_request = 1'b0;
    int         ticks_sent = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;

    function automatic void start_half(input logic [4:0] next);
        ph = next;
        half_tmr = half_cfg;
    endfunction

    function automatic void release_scl(input logic [4:0] next);
        clk_drv = 1'b1;
        stretch_tmr = '0;
        ph = next;
    endfunction

    function automatic void end_cmd(input logic ok, input logic [1:0] err);
        ph = PH_IDLE;
        step_done = 1'b1;
        step_ok = ok;
        err_held = err;
    endfunction

    function automatic void shift_out();
        dat_drv = shifter[7];
        shifter = shifter << 1;
    endfunction

    function automatic i2cbb_result_t master_step(input logic [2:0] act, input logic [7:0] tx,
                                                  input logic fin, input logic scl,
                                                  input logic sda);
        i2cbb_result_t r;
        step_done = 1'b0;
        step_ok = 1'b0;
        if (ph == PH_IDLE)
        begin
            if (act >= ACT_START && act <= ACT_READ)
            begin
                err_held = ERR_NONE;
                bit_cnt = '0;
                case (act)
                    ACT_START:
                    begin
                        dat_drv = 1'b1;
                        release_scl(ST_SCL);
                    end
                    ACT_STOP:
                    begin
                        clk_drv = 1'b0;
                        dat_drv = 1'b0;
                        start_half(SP_H1);
                    end
                    ACT_WRITE:
                    begin
                        shifter = tx;
                        shift_out();
                        start_half(WR_SET);
                    end
                    default:
                    begin
                        dat_drv = 1'b1;
                        shifter = '0;
                        nack_pend = fin;
                        start_half(RD_SET);
                    end
                endcase
            end
        end
        else if (ph > RK_LO)
            ph = PH_IDLE;
        else if (ph inside {ST_SCL, SP_SCL, WR_SCL, WA_SCL, RD_SCL, RK_SCL})
        begin
            if (scl)
                start_half(ph + 5'd1);
            else
            begin
                stretch_tmr = stretch_tmr + 9'd1;
                if (stretch_tmr >= stretch_cfg)
                begin
                    if (ph == SP_SCL)
                        dat_drv = 1'b1;
                    end_cmd(1'b0, ERR_STRETCH);
                end
            end
        end
        else if (half_tmr > 8'd1)
            half_tmr = half_tmr - 8'd1;
        else
        begin
            half_tmr = '0;
            case (ph)
                ST_H1:
                    if (!sda)
                        end_cmd(1'b0, ERR_SDA_LOW);
                    else
                    begin
                        dat_drv = 1'b0;
                        start_half(ST_H2);
                    end
                ST_H2:
                begin
                    clk_drv = 1'b0;
                    start_half(ST_H3);
                end
                ST_H3:  end_cmd(1'b1, ERR_NONE);
                SP_H1:  release_scl(SP_SCL);
                SP_H2:
                begin
                    dat_drv = 1'b1;
                    start_half(SP_H3);
                end
                SP_H3:
                    if (!sda)
                        end_cmd(1'b0, ERR_SDA_LOW);
                    else
                        end_cmd(1'b1, ERR_NONE);
                WR_SET: release_scl(WR_SCL);
                WR_HI:
                begin
                    clk_drv = 1'b0;
                    start_half(WR_LO);
                end
                WR_LO:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BITS_PER_BYTE)
                    begin
                        shift_out();
                        start_half(WR_SET);
                    end
                    else
                    begin
                        dat_drv = 1'b1;
                        start_half(WA_SET);
                    end
                end
                WA_SET: release_scl(WA_SCL);
                WA_HI:
                begin
                    nack_pend = sda;
                    clk_drv = 1'b0;
                    start_half(WA_LO);
                end
                WA_LO:
                    if (nack_pend)
                        end_cmd(1'b0, ERR_NACK);
                    else
                        end_cmd(1'b1, ERR_NONE);
                RD_SET: release_scl(RD_SCL);
                RD_HI:
                begin
                    shifter = {shifter[6:0], sda};
                    clk_drv = 1'b0;
                    start_half(RD_LO);
                end
                RD_LO:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BITS_PER_BYTE)
                        start_half(RD_SET);
                    else
                    begin
                        dat_drv = nack_pend;
                        start_half(RK_SET);
                    end
                end
                RK_SET: release_scl(RK_SCL);
                RK_HI:
                begin
                    clk_drv = 1'b0;
                    dat_drv = 1'b1;
                    start_half(RK_LO);
                end
                RK_LO:
                begin
                    rx_held = shifter;
                    end_cmd(1'b1, ERR_NONE);
                end
                default: ph = PH_IDLE;
            endcase
        end
        r.scl_release = clk_drv;
        r.sda_release = dat_drv;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = step_done;
        r.success     = step_done && step_ok;
        r.rx_byte     = rx_held;
        r.error_code  = err_t'(err_held);
        return r;
    endfunction

    // Levels seen on the wires, given the current drives and the simulated slave.
    task automatic bus_levels(output logic s, output logic d);
        s = clk_drv && !hold_scl;
        if (s && bus_noise && stretch_left == 0 && $urandom_range(99) < 8)
            stretch_left = $urandom_range(1, stretch_cfg + 2);
        if (stretch_left != 0)
        begin
            s = 1'b0;
            stretch_left--;
        end
        if (!dat_drv || hold_sda)
            d = 1'b0;
        else if (ph inside {WA_SCL, WA_HI})
            d = ack_level;
        else if (ph inside {RD_SCL, RD_HI})
            d = rd_data[3'd7 - bit_cnt[2:0]];
        else
            d = 1'b1;
        if (bus_noise && $urandom_range(99) < 3)
            d = ~d;
    endtask

    task automatic send_tick(input logic [2:0] act, input logic [7:0] tx, input logic fin,
                             input logic scl, input logic sda);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        tx_byte    <= tx;
        final_read <= fin;
        scl_level  <= scl;
        sda_level  <= sda;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_results.push_back(master_step(act, tx, fin, scl, sda));
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic run_command(input logic [2:0] act, input logic [7:0] tx, input logic fin);
        logic s;
        logic d;
        logic [2:0] stray;
        bus_levels(s, d);
        send_tick(act, tx, fin, s, d);
        while (ph != PH_IDLE)
        begin
            stray = ($urandom_range(99) < 30) ? 3'($urandom_range(7)) : ACT_TICK;
            bus_levels(s, d);
            send_tick(stray, 8'($urandom), 1'($urandom_range(1)), s, d);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain_results();
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_HALF_PERIOD)
            half_cfg = val;
        else
            stretch_cfg = val;
    endtask

    task automatic set_config(input logic [7:0] half, input logic [7:0] limit);
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_STRETCH, limit);
    endtask

    task automatic test_ignored_actions();
        send_tick(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
            send_tick(3'(a), 8'hFF, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_start_stop();
        set_config(8'd1, 8'd5);
        run_command(ACT_START, 8'h00, 1'b0);
        run_command(ACT_STOP, 8'h00, 1'b0);
        hold_sda = 1'b1;
        run_command(ACT_START, 8'h00, 1'b0);
        run_command(ACT_STOP, 8'h00, 1'b0);
        hold_sda = 1'b0;
    endtask

    task automatic test_byte_transfers();
        ack_level = 1'b0;
        run_command(ACT_WRITE, 8'hFF, 1'b0);
        ack_level = 1'b1;
        run_command(ACT_WRITE, 8'h00, 1'b1);
        ack_level = 1'b0;
        run_command(ACT_WRITE, 8'hA5, 1'b0);
        rd_data = 8'hFF;
        run_command(ACT_READ, 8'h00, 1'b0);
        rd_data = 8'h00;
        run_command(ACT_READ, 8'hFF, 1'b1);
        rd_data = 8'h5A;
        run_command(ACT_READ, 8'h00, 1'b0);
    endtask

    task automatic test_clock_stretch();
        set_config(8'd1, 8'd0);
        hold_scl = 1'b1;
        run_command(ACT_START, 8'h00, 1'b0);
        run_command(ACT_STOP, 8'h00, 1'b0);
        set_config(8'd1, 8'd255);
        run_command(ACT_WRITE, 8'h3C, 1'b0);
        hold_scl = 1'b0;
    endtask

    task automatic test_half_period_extremes();
        set_config(8'd0, 8'd5);
        run_command(ACT_START, 8'h00, 1'b0);
        run_command(ACT_WRITE, 8'h96, 1'b0);
        run_command(ACT_STOP, 8'h00, 1'b0);
        set_config(8'd255, 8'd5);
        hold_sda = 1'b1;
        run_command(ACT_START, 8'h00, 1'b0);
        hold_sda = 1'b0;
        set_config(HALF_PERIOD_RESET, STRETCH_RESET);
    endtask

    task automatic random_transfer();
        int n;
        logic reading;
        logic [7:0] addr;
        logic s;
        logic d;
        if ($urandom_range(99) < 30)
        begin
            bus_levels(s, d);
            send_tick(3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)), 8'($urandom),
                      1'($urandom_range(1)), s, d);
        end
        n = $urandom_range(1, 3);
        reading = 1'($urandom_range(1));
        addr = 8'($urandom);
        addr[0] = reading;
        hold_sda = ($urandom_range(99) < 5);
        run_command(ACT_START, 8'($urandom), 1'($urandom_range(1)));
        hold_sda = 1'b0;
        ack_level = ($urandom_range(99) < 10);
        run_command(ACT_WRITE, addr, 1'($urandom_range(1)));
        for (int i = 0; i < n; i++)
        begin
            if (reading)
            begin
                rd_data = 8'($urandom);
                run_command(ACT_READ, 8'($urandom), i == n - 1);
            end
            else
            begin
                ack_level = ($urandom_range(99) < 10);
                run_command(ACT_WRITE, 8'($urandom), 1'($urandom_range(1)));
            end
        end
        hold_sda = ($urandom_range(99) < 5);
        run_command(ACT_STOP, 8'($urandom), 1'($urandom_range(1)));
        hold_sda = 1'b0;
    endtask

    task automatic random_command();
        hold_scl = ($urandom_range(99) < 10);
        hold_sda = ($urandom_range(99) < 10);
        ack_level = 1'($urandom_range(1));
        rd_data = 8'($urandom);
        run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
        hold_scl = 1'b0;
        hold_sda = 1'b0;
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int p = 0; p < 3; p++)
        begin
            set_config(8'($urandom_range(1, 2)), 8'($urandom_range(1, 8)));
            send_idle_pct = (p == 0) ? 9 : (p == 1) ? 74 : 0;
            recv_idle_pct = (p == 0) ? 74 : (p == 1) ? 9 : 0;
            bus_noise = 1'b1;
            if (p == 2)
                stall_request = 1'b1;
            goal = ticks_sent + 40;
            while (ticks_sent < goal)
            begin
                if ($urandom_range(99) < 80)
                    random_transfer();
                else
                    random_command();
            end
        end
        bus_noise = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : check_result
        i2cbb_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result request arrived with nothing expected");
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("scl_release", 8'(want.scl_release), 8'(scl_release));
                compare_field("sda_release", 8'(want.sda_release), 8'(sda_release));
                compare_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                compare_field("done_res", 8'(want.done_res), 8'(done_res));
                compare_field("success", 8'(want.success), 8'(success));
                compare_field("rx_byte", want.rx_byte, rx_byte);
                compare_field("error_code", 8'(want.error_code), 8'(error_code));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                stall_request = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_HALF_PERIOD;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_TICK;
        tx_byte      = '0;
        final_read   = 1'b0;
        scl_level    = 1'b1;
        sda_level    = 1'b1;
        out_ready    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_ignored_actions();
        test_start_stop();
        test_byte_transfers();
        test_clock_stretch();
        test_half_period_extremes();
        test_random_traffic();
        drain_results();
        repeat (6) @(negedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
